>>> hw/rtl/sc2a_pkg.sv
package sc2a_pkg;

   // Ring buffer depth. One slot always stays empty, so it holds FIFO_DEPTH-1 characters.
   localparam int FIFO_DEPTH = 128;
   localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CHAR_W     = 7;
   localparam int CODE_W     = 7;

   typedef logic [CHAR_W-1:0] char_type;
   typedef logic [CODE_W-1:0] code_type;
   typedef logic [PTR_W-1:0]  ptr_type;

   // tuser codes on the request channel
   localparam logic ACT_SCAN = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // set-1 make codes with special handling
   localparam code_type CODE_LSHIFT = 7'h2A;
   localparam code_type CODE_RSHIFT = 7'h36;
   localparam code_type CODE_CAPS   = 7'h3A;

   localparam char_type CHAR_NONE   = 7'h00;
   localparam char_type CHAR_LOW_A  = 7'h61;
   localparam char_type CHAR_LOW_Z  = 7'h7A;
   localparam char_type CASE_OFFSET = 7'h20;

   // unshifted key map, zero for unmapped codes
   function automatic char_type plain_char(input code_type code);
      char_type ch;
      ch = CHAR_NONE;
      case (code)
         7'h02: ch = 7'h31;  // 1
         7'h03: ch = 7'h32;
         7'h04: ch = 7'h33;
         7'h05: ch = 7'h34;
         7'h06: ch = 7'h35;
         7'h07: ch = 7'h36;
         7'h08: ch = 7'h37;
         7'h09: ch = 7'h38;
         7'h0A: ch = 7'h39;
         7'h0B: ch = 7'h30;  // 0
         7'h0C: ch = 7'h2D;  // -
         7'h0D: ch = 7'h3D;  // =
         7'h0E: ch = 7'h08;  // backspace
         7'h10: ch = 7'h71;  // q
         7'h11: ch = 7'h77;
         7'h12: ch = 7'h65;
         7'h13: ch = 7'h72;
         7'h14: ch = 7'h74;
         7'h15: ch = 7'h79;
         7'h16: ch = 7'h75;
         7'h17: ch = 7'h69;
         7'h18: ch = 7'h6F;
         7'h19: ch = 7'h70;  // p
         7'h1A: ch = 7'h5B;  // [
         7'h1B: ch = 7'h5D;  // ]
         7'h1C: ch = 7'h0A;  // enter
         7'h1E: ch = 7'h61;  // a
         7'h1F: ch = 7'h73;
         7'h20: ch = 7'h64;
         7'h21: ch = 7'h66;
         7'h22: ch = 7'h67;
         7'h23: ch = 7'h68;
         7'h24: ch = 7'h6A;
         7'h25: ch = 7'h6B;
         7'h26: ch = 7'h6C;  // l
         7'h27: ch = 7'h3B;  // ;
         7'h28: ch = 7'h27;  // quote
         7'h29: ch = 7'h60;  // backtick
         7'h2B: ch = 7'h5C;  // backslash
         7'h2C: ch = 7'h7A;  // z
         7'h2D: ch = 7'h78;
         7'h2E: ch = 7'h63;
         7'h2F: ch = 7'h76;
         7'h30: ch = 7'h62;
         7'h31: ch = 7'h6E;
         7'h32: ch = 7'h6D;  // m
         7'h33: ch = 7'h2C;  // ,
         7'h34: ch = 7'h2E;  // .
         7'h35: ch = 7'h2F;  // /
         7'h39: ch = 7'h20;  // space
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

   // shifted map for non-letter keys; letters are upcased separately
   function automatic char_type shift_char(input code_type code);
      char_type ch;
      ch = CHAR_NONE;
      case (code)
         7'h02: ch = 7'h21;  // !
         7'h03: ch = 7'h40;  // @
         7'h04: ch = 7'h23;  // #
         7'h05: ch = 7'h24;  // $
         7'h06: ch = 7'h25;  // %
         7'h07: ch = 7'h5E;  // ^
         7'h08: ch = 7'h26;  // &
         7'h09: ch = 7'h2A;  // *
         7'h0A: ch = 7'h28;  // (
         7'h0B: ch = 7'h29;  // )
         7'h0C: ch = 7'h5F;  // _
         7'h0D: ch = 7'h2B;  // +
         7'h1A: ch = 7'h7B;  // {
         7'h1B: ch = 7'h7D;  // }
         7'h27: ch = 7'h3A;  // :
         7'h28: ch = 7'h22;  // double quote
         7'h29: ch = 7'h7E;  // ~
         7'h2B: ch = 7'h7C;  // |
         7'h33: ch = 7'h3C;  // <
         7'h34: ch = 7'h3E;  // >
         7'h35: ch = 7'h3F;  // ?
         default: ch = CHAR_NONE;
      endcase
      return ch;
   endfunction

endpackage

>>> hw/rtl/sc2a_ram.sv
module sc2a_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/sc2a_decode.sv
module sc2a_decode (
   input  sc2a_pkg::code_type code,
   input  logic               shift_held,
   input  logic               caps_on,
   output sc2a_pkg::char_type ch
);
   import sc2a_pkg::*;

   char_type plain;
   char_type shifted;
   logic     is_letter;

   assign plain     = plain_char(code);
   assign shifted   = shift_char(code);
   assign is_letter = (plain >= CHAR_LOW_A) && (plain <= CHAR_LOW_Z);

   // caps lock flips the shift sense for letters only
   always_comb begin
      ch = plain;
      if (is_letter) begin
         if (shift_held ^ caps_on) begin
            ch = plain - CASE_OFFSET;
         end
      end else if (shift_held && (shifted != CHAR_NONE)) begin
         ch = shifted;
      end
   end

endmodule

>>> hw/rtl/scancode_to_ascii_fifo.sv
// Set-1 keyboard scancode decoder with a character FIFO. Each request
// transaction carries either a scancode (req_tuser = 0) or a read request
// (req_tuser = 1), and each one yields exactly one response transaction.
// Scancodes track left/right shift and caps lock; other key presses map to
// ASCII and, if nonzero, are pushed into a ring buffer of FIFO_DEPTH entries
// (one slot always kept free, so FIFO_DEPTH-1 characters fit). A push to a
// full buffer is discarded and reported through the dropped flag. A read
// pops the oldest character, or returns 0 with was_empty set. Scancode
// responses carry char_out = 0. Throughput is one transaction per clock while
// the receiver takes each response: decode, flag update and pointer step
// finish in the accept cycle, the buffer RAM's registered read port holds the
// response data, and the response is valid in the cycle after accept.
module scancode_to_ascii_fifo (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] scan_byte
   input  logic [0:0] req_tuser,   // [0] action
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [6:0] char_out, [7] zero
   output logic [1:0] rsp_tuser    // [0] was_empty, [1] dropped
);
   import sc2a_pkg::*;

   // architectural state
   logic    lshift_ff, lshift_in;
   logic    rshift_ff, rshift_in;
   logic    caps_ff,   caps_in;
   ptr_type wr_ptr_ff, wr_ptr_in;
   ptr_type rd_ptr_ff, rd_ptr_in;

   // response register; popped character itself sits in the RAM read register
   logic rsp_valid_ff, rsp_valid_in;
   logic pop_ff,       pop_in;
   logic empty_ff,     empty_in;
   logic drop_ff,      drop_in;

   logic     accept;
   logic     action;
   code_type code;
   logic     release_key;
   logic     is_special;
   char_type dec_char;
   char_type rd_char;
   logic     fifo_empty;
   logic     fifo_full;
   ptr_type  wr_ptr_next;
   ptr_type  rd_ptr_next;
   logic     push_req;
   logic     do_push;
   logic     do_pop;

   // take a new transaction whenever the response slot is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign action      = req_tuser[0];
   assign code        = req_tdata[6:0];
   assign release_key = req_tdata[7];
   assign is_special  = (code == CODE_LSHIFT) || (code == CODE_RSHIFT) ||
                        (code == CODE_CAPS);

   sc2a_decode u_decode (
      .code       (code),
      .shift_held (lshift_ff | rshift_ff),
      .caps_on    (caps_ff),
      .ch         (dec_char)
   );

   // ring pointers wrap at FIFO_DEPTH
   assign wr_ptr_next = (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
   assign rd_ptr_next = (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
   assign fifo_empty  = (rd_ptr_ff == wr_ptr_ff);
   assign fifo_full   = (wr_ptr_next == rd_ptr_ff);

   assign push_req = accept && (action == ACT_SCAN) && !release_key && !is_special &&
                     (dec_char != CHAR_NONE);
   assign do_push  = push_req && !fifo_full;
   assign do_pop   = accept && (action == ACT_READ) && !fifo_empty;

   sc2a_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (FIFO_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_push),
      .wr_addr (wr_ptr_ff),
      .wr_data (dec_char),
      .rd_en   (do_pop),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_char)
   );

   always_comb begin
      lshift_in = lshift_ff;
      rshift_in = rshift_ff;
      caps_in   = caps_ff;
      if (accept && (action == ACT_SCAN)) begin
         case (code)
            CODE_LSHIFT: lshift_in = !release_key;
            CODE_RSHIFT: rshift_in = !release_key;
            CODE_CAPS: begin
               if (!release_key) begin
                  caps_in = !caps_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign wr_ptr_in = do_push ? wr_ptr_next : wr_ptr_ff;
   assign rd_ptr_in = do_pop  ? rd_ptr_next : rd_ptr_ff;

   // response slot: load on accept, clear once taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      pop_in       = pop_ff;
      empty_in     = empty_ff;
      drop_in      = drop_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         pop_in       = do_pop;
         empty_in     = (action == ACT_READ) && fifo_empty;
         drop_in      = push_req && fifo_full;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lshift_ff    <= 1'b0;
         rshift_ff    <= 1'b0;
         caps_ff      <= 1'b0;
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lshift_ff    <= lshift_in;
         rshift_ff    <= rshift_in;
         caps_ff      <= caps_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_ff   <= pop_in;
      empty_ff <= empty_in;
      drop_ff  <= drop_in;
   end

   // RAM read data holds until the next pop, which only follows an accept
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, (pop_ff ? rd_char : CHAR_NONE)};
   assign rsp_tuser  = {drop_ff, empty_ff};

endmodule

>>> sim/tb_scancode_to_ascii_fifo.sv
module tb_scancode_to_ascii_fifo;
   timeunit 1ns;
   timeprecision 1ps;

   import sc2a_pkg::*;

   // run length knobs
   localparam int ITEM_TARGET  = 1150;   // counted request transactions
   localparam int HOLD_CYCLES  = 300;    // long receiver hold-off in the last phase
   localparam int DRAIN_CYCLES = 8;      // settle time after the last response
   localparam int LIMIT_CYCLES = 300000; // watchdog

   localparam logic [7:0] KEY_RELEASE = 8'h80;

   // one response as the block should produce it
   typedef struct packed {
      char_type ch;
      logic     empty;
      logic     drop;
   } key_result_type;

   // Keyboard state tracker plus the queue of responses it predicts.
   class key_decode_board;
      char_type       plain_tab[128];
      char_type       shift_tab[128];
      logic           lshift;
      logic           rshift;
      logic           caps;
      char_type       ring[FIFO_DEPTH];
      int             wr_idx;
      int             rd_idx;
      key_result_type result_q[$];
      int             mismatches;
      int             presses;
      int             reads;
      int             empty_reads;
      int             drops;

      function new();
         for (int i = 0; i < 128; i++) begin
            plain_tab[i] = CHAR_NONE;
            shift_tab[i] = CHAR_NONE;
         end
         load_row(8'h02, "1234567890-=", 1'b0);
         load_row(8'h10, "qwertyuiop[]", 1'b0);
         load_row(8'h1E, "asdfghjkl;'", 1'b0);
         load_row(8'h2B, "\\zxcvbnm,./", 1'b0);
         plain_tab[8'h29] = 7'h60;   // backtick
         plain_tab[8'h0E] = 7'h08;   // backspace
         plain_tab[8'h1C] = 7'h0A;   // enter
         plain_tab[8'h39] = 7'h20;   // space
         load_row(8'h02, "!@#$%^&*()_+", 1'b1);
         load_row(8'h1A, "{}", 1'b1);
         load_row(8'h27, ":\"~", 1'b1);
         load_row(8'h2B, "|", 1'b1);
         load_row(8'h33, "<>?", 1'b1);
         lshift      = 1'b0;
         rshift      = 1'b0;
         caps        = 1'b0;
         wr_idx      = 0;
         rd_idx      = 0;
         mismatches  = 0;
         presses     = 0;
         reads       = 0;
         empty_reads = 0;
         drops       = 0;
      endfunction

      function void load_row(int base, string keys, bit shifted);
         for (int i = 0; i < keys.len(); i++) begin
            if (shifted) shift_tab[base + i] = char_type'(keys[i]);
            else         plain_tab[base + i] = char_type'(keys[i]);
         end
      endfunction

      // caps lock flips the shift sense for letters only
      function char_type decode(code_type code);
         char_type ch;
         logic     up;
         ch = plain_tab[code];
         up = lshift | rshift;
         if (ch >= CHAR_LOW_A && ch <= CHAR_LOW_Z) begin
            if (caps) up = !up;
            if (up) ch = ch - CASE_OFFSET;
         end else if (up && shift_tab[code] != CHAR_NONE) begin
            ch = shift_tab[code];
         end
         return ch;
      endfunction

      function void note_request(logic action, logic [7:0] scan);
         key_result_type r;
         code_type       code;
         logic           rel;
         char_type       ch;
         int             nxt;
         r    = '0;
         code = scan[6:0];
         rel  = scan[7];
         if (action == ACT_READ) begin
            reads++;
            if (rd_idx == wr_idx) begin
               r.empty = 1'b1;
               empty_reads++;
            end else begin
               r.ch   = ring[rd_idx];
               rd_idx = (rd_idx + 1) % FIFO_DEPTH;
            end
         end else if (code == CODE_LSHIFT) begin
            lshift = !rel;
         end else if (code == CODE_RSHIFT) begin
            rshift = !rel;
         end else if (code == CODE_CAPS) begin
            if (!rel) caps = !caps;
         end else if (!rel) begin
            presses++;
            ch = decode(code);
            if (ch != CHAR_NONE) begin
               nxt = (wr_idx + 1) % FIFO_DEPTH;
               if (nxt == rd_idx) begin
                  r.drop = 1'b1;   // buffer full, character lost
                  drops++;
               end else begin
                  ring[wr_idx] = ch;
                  wr_idx       = nxt;
               end
            end
         end
         result_q.push_back(r);
      endfunction

      function void check_response(logic [7:0] tdata, logic [1:0] tuser);
         key_result_type want;
         if (result_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: response with nothing pending: tdata=%h tuser=%b",
                        tdata, tuser);
            return;
         end
         want = result_q.pop_front();
         if (tdata !== {1'b0, want.ch} || tuser[0] !== want.empty
             || tuser[1] !== want.drop) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: char exp %h got %h, empty exp %b got %b, drop exp %b got %b",
                        {1'b0, want.ch}, tdata, want.empty, tuser[0], want.drop, tuser[1]);
         end
      endfunction

      function int pending();
         return result_q.size();
      endfunction
   endclass

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] scan_byte
   logic [0:0] req_tuser  = ACT_SCAN; // [0] action
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [6:0] char_out, [7] zero
   logic [1:0] rsp_tuser;           // [0] was_empty, [1] dropped

   key_decode_board board = new();

   int   send_idle_pct = 0;   // chance per cycle that the sender holds back
   int   recv_idle_pct = 0;   // chance per cycle that the receiver stalls
   int   counted_items = 0;   // accepted request transactions
   int   cycles        = 0;
   logic hold_go       = 1'b0;
   logic hold_rsp      = 1'b0;

   scancode_to_ascii_fifo dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d responses outstanding",
                  cycles, board.pending());
         $display("scancode_to_ascii_fifo test failed");
         $finish;
      end
   end

   // receiver: random stalls, forced low during the hold-off window
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !hold_rsp && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // long hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      @(posedge clock);
      while (!hold_go) @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   // Monitor: values read right at the edge are the ones the block sampled.
   // The response check goes first; a request accepted this edge cannot
   // have its response out yet.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready)
            board.check_response(rsp_tdata, rsp_tuser);
         if (req_tvalid && req_tready)
            board.note_request(req_tuser[0], req_tdata);
      end
   end

   // one request transaction; valid stays up after the handshake so
   // back-to-back items need no bubble
   task automatic send_item(input logic action, input logic [7:0] scan);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid   <= 1'b1;
      req_tdata    <= scan;
      req_tuser[0] <= action;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      counted_items++;
   endtask

   function automatic code_type pick_key();
      code_type code;
      do code = code_type'($urandom_range(8'h02, 8'h39));
      while (board.plain_tab[code] == CHAR_NONE);
      return code;
   endfunction

   // burst of presses, long enough to overrun the buffer
   task automatic flood_keys(input int count);
      repeat (count) send_item(ACT_SCAN, {1'b0, pick_key()});
   endtask

   task automatic drain_reads(input int count);
      repeat (count) send_item(ACT_READ, 8'($urandom_range(255)));
   endtask

   // mostly typing-like traffic, with some reads, caps toggles and noise
   task automatic random_traffic(input int upto);
      int       pick;
      int       nkeys;
      bit       shifted;
      code_type shift_code;
      code_type key;
      while (counted_items < upto) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            shifted    = ($urandom_range(3) == 0);
            shift_code = $urandom_range(1) ? CODE_LSHIFT : CODE_RSHIFT;
            if (shifted) send_item(ACT_SCAN, {1'b0, shift_code});
            nkeys = $urandom_range(1, 8);
            repeat (nkeys) begin
               key = pick_key();
               send_item(ACT_SCAN, {1'b0, key});
               if ($urandom_range(1)) send_item(ACT_SCAN, KEY_RELEASE | key);
            end
            // now and then the shift release goes missing
            if (shifted && $urandom_range(9) != 0)
               send_item(ACT_SCAN, KEY_RELEASE | shift_code);
         end else if (pick < 65) begin
            drain_reads($urandom_range(1, 12));
         end else if (pick < 72) begin
            send_item(ACT_SCAN, {1'b0, CODE_CAPS});
            send_item(ACT_SCAN, KEY_RELEASE | CODE_CAPS);
         end else if (pick < 74) begin
            flood_keys($urandom_range(130, 140));
         end else if (pick < 76) begin
            drain_reads($urandom_range(130, 140));
         end else begin
            send_item(1'($urandom_range(1)), 8'($urandom_range(255)));
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty read, unmapped codes, releases, caps and shift
      send_item(ACT_READ, 8'h00);                   // read on empty buffer
      send_item(ACT_SCAN, 8'h1E);                   // a
      send_item(ACT_SCAN, 8'h00);                   // unmapped
      send_item(ACT_SCAN, 8'h7F);                   // unmapped, top code
      send_item(ACT_SCAN, 8'h9E);                   // release of a plain key
      send_item(ACT_SCAN, {1'b0, CODE_CAPS});
      send_item(ACT_SCAN, KEY_RELEASE | CODE_CAPS); // caps release, no toggle
      send_item(ACT_SCAN, 8'h1E);                   // A under caps
      send_item(ACT_SCAN, 8'h02);                   // digit ignores caps
      send_item(ACT_SCAN, {1'b0, CODE_LSHIFT});
      send_item(ACT_SCAN, 8'h1E);                   // caps plus shift gives a
      send_item(ACT_SCAN, 8'h02);                   // !
      send_item(ACT_SCAN, 8'h1C);                   // enter has no shifted form
      send_item(ACT_SCAN, 8'h39);                   // space, same
      send_item(ACT_SCAN, 8'h0E);                   // backspace, same
      send_item(ACT_SCAN, 8'h1A);                   // {
      send_item(ACT_SCAN, KEY_RELEASE | CODE_LSHIFT);
      send_item(ACT_SCAN, {1'b0, CODE_RSHIFT});
      send_item(ACT_SCAN, 8'h35);                   // ?
      send_item(ACT_SCAN, KEY_RELEASE | CODE_RSHIFT);
      send_item(ACT_SCAN, {1'b0, CODE_CAPS});       // caps off again
      send_item(ACT_SCAN, 8'h1B);                   // ]
      send_item(ACT_SCAN, 8'hFF);                   // release of top code
      send_item(ACT_READ, 8'hFF);
      send_item(ACT_READ, 8'h5A);

      // sender mostly busy, receiver stalls a lot
      send_idle_pct = 18;
      recv_idle_pct = 57;
      random_traffic(400);

      // the other way round
      send_idle_pct = 57;
      recv_idle_pct = 18;
      random_traffic(780);

      // no idling; the receiver holds off while presses keep coming
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_go <= 1'b1;
      flood_keys(135);
      drain_reads(135);
      random_traffic(ITEM_TARGET);
      req_tvalid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d transactions: %0d key presses, %0d reads (%0d on empty buffer)",
               counted_items, board.presses, board.reads, board.empty_reads);
      $display("%0d characters dropped on a full buffer, %0d mismatches, %0d cycles",
               board.drops, board.mismatches, cycles);
      if (board.mismatches == 0 && board.pending() == 0) begin
         $display("scancode_to_ascii_fifo test passed");
      end else begin
         $display("scancode_to_ascii_fifo test failed");
      end
      $finish;
   end

endmodule

>>> files.f
hw/rtl/sc2a_pkg.sv
hw/rtl/sc2a_ram.sv
hw/rtl/sc2a_decode.sv
hw/rtl/scancode_to_ascii_fifo.sv
sim/tb_scancode_to_ascii_fifo.sv
